FILE: sv/srsw_pkg.sv
package srsw_pkg;

  // Window geometry and payload width
  localparam int WINDOW_SIZE   = 4;
  localparam int SEQ_SPACE     = 8;
  localparam int PAYLOAD_WIDTH = 64;

  // Field widths at the ports
  localparam int SEQ_FW = 3;
  localparam int PAY_FW = 64;

  localparam int SEQ_W   = $clog2(SEQ_SPACE);
  localparam int SEQ_W1  = SEQ_W + 1;
  localparam int WIN_MOD = WINDOW_SIZE % SEQ_SPACE;

  typedef logic [SEQ_W-1:0]         seq_t;
  typedef logic [PAYLOAD_WIDTH-1:0] pay_t;

  typedef enum logic [1:0] {
    FUNC_SEND    = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_TIMEOUT = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_STOP    = 2'd1,
    TMR_RESTART = 2'd2
  } timer_t;

  typedef struct packed {
    logic accepted;
    logic transmit;
    seq_t tx_seq;
    pay_t tx_payload;
    timer_t timer_action;
    seq_t timer_slot;
  } result_t;

  typedef struct packed {
    logic start;
    seq_t start_seq;
    seq_t limit_seq;
  } slide_req_t;

  typedef struct packed {
    logic done;
    seq_t base;
  } slide_sts_t;

  // Step one sequence number forward, wrapping at the sequence space
  function automatic seq_t seq_inc(input seq_t s);
    seq_t r;
    if (s == seq_t'(SEQ_SPACE - 1)) r = '0;
    else                            r = s + seq_t'(1);
    return r;
  endfunction

  // (s + window size) mod sequence space
  function automatic seq_t seq_add_win(input seq_t s);
    logic [SEQ_W1-1:0] sum;
    sum = {1'b0, s} + SEQ_W1'(WIN_MOD);
    if (sum >= SEQ_W1'(SEQ_SPACE)) sum = sum - SEQ_W1'(SEQ_SPACE);
    return sum[SEQ_W-1:0];
  endfunction

  // (a - b) mod sequence space
  function automatic seq_t seq_dist(input seq_t a, input seq_t b);
    logic [SEQ_W1-1:0] d;
    d = {1'b0, a} + ((a < b) ? SEQ_W1'(SEQ_SPACE) : SEQ_W1'(0)) - {1'b0, b};
    return d[SEQ_W-1:0];
  endfunction

endpackage

FILE: sv/srsw_pay_mem.sv
module srsw_pay_mem
  import srsw_pkg::*;
(
  input  logic clk,
  input  logic wr_en,
  input  seq_t wr_addr,
  input  pay_t wr_data,
  input  logic rd_en,
  input  seq_t rd_addr,
  output pay_t rd_data
);

  pay_t mem [SEQ_SPACE];
  pay_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/srsw_slide.sv
module srsw_slide
  import srsw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  slide_req_t           req,
  input  logic [SEQ_SPACE-1:0] acked,
  output slide_sts_t           sts
);

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  seq_t ptr_r, ptr_nxt;
  seq_t limit_r, limit_nxt;

  // One slot per cycle: advance while the slot is acked and not next_seq
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    ptr_nxt   = ptr_r;
    limit_nxt = limit_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      ptr_nxt   = req.start_seq;
      limit_nxt = req.limit_seq;
    end else if (busy_r) begin
      if (ptr_r != limit_r && acked[ptr_r]) begin
        ptr_nxt = seq_inc(ptr_r);
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      ptr_r   <= ptr_nxt;
      limit_r <= limit_nxt;
    end
  end

  assign sts.done = done_r;
  assign sts.base = ptr_r;

endmodule

FILE: sv/selective_repeat_sender_window.sv
// Sender side of a selective-repeat ARQ window.
//
// Input channel (in_valid / in_ready): one item is one event: a send
// (in_func = 0, in_payload_word), an acknowledgement (in_func = 1,
// in_ack_number, in_checksum_ok) or a timer expiry (in_func = 2,
// in_timed_out_seq). Every item yields exactly one result item on the
// output channel (out_valid / out_ready) with the transmit request, the
// timer action and the window state after the event.
//
// Steps: a send, a refused or ignored event, or an ack that is not the
// base passes the exec and emit steps; a timeout adds a read step for
// the registered read of the payload memory. An ack of the base adds a
// slide step in which the slide unit walks the acked flags one slot per
// cycle. in_ready rises together with out_valid, and no new item is
// taken while one is still at work.
// Reset (rst_n low, synchronous) clears base, next sequence and all
// acked flags; payload memory contents are left as they are.
// When the receiver stalls, the result holds in the output register and
// one more item may be taken and worked; it waits in the emit step until
// the output register frees.
module selective_repeat_sender_window
  import srsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_payload_word,
  input  logic [2:0]  in_ack_number,
  input  logic        in_checksum_ok,
  input  logic [2:0]  in_timed_out_seq,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_transmit,
  output logic [2:0]  out_tx_seq,
  output logic [63:0] out_tx_payload,
  output logic [1:0]  out_timer_action,
  output logic [2:0]  out_timer_slot,
  output logic [2:0]  out_window_base,
  output logic [2:0]  out_next_sequence,
  output logic        out_window_full
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SLIDE,
    S_READ,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  seq_t                 base_r, base_nxt;
  seq_t                 next_r, next_nxt;
  logic [SEQ_SPACE-1:0] acked_r, acked_nxt;

  // Captured input item
  logic [1:0]        func_r, func_nxt;
  pay_t              pay_r, pay_nxt;
  logic [SEQ_FW-1:0] ack_r, ack_nxt;
  logic              ok_r, ok_nxt;
  logic [SEQ_FW-1:0] tos_r, tos_nxt;

  // Result under construction and the output register
  result_t res_r, res_nxt;
  result_t out_res_r, out_res_nxt;
  seq_t    out_base_r, out_base_nxt;
  seq_t    out_next_r, out_next_nxt;
  logic    out_full_r, out_full_nxt;
  logic    out_valid_r, out_valid_nxt;

  // Payload memory and slide unit hookups
  logic       mem_wr_en, mem_rd_en;
  seq_t       mem_rd_addr;
  pay_t       mem_rd_data;
  slide_req_t slide_req;
  slide_sts_t slide_sts;

  seq_t ack_s;
  seq_t tos_s;

  assign ack_s = seq_t'(ack_r);
  assign tos_s = seq_t'(tos_r);

  srsw_pay_mem u_pay_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (next_r),
    .wr_data (pay_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  srsw_slide u_slide (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (slide_req),
    .acked (acked_r),
    .sts   (slide_sts)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    acked_nxt     = acked_r;
    func_nxt      = func_r;
    pay_nxt       = pay_r;
    ack_nxt       = ack_r;
    ok_nxt        = ok_r;
    tos_nxt       = tos_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_base_nxt  = out_base_r;
    out_next_nxt  = out_next_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r && !out_ready;

    mem_wr_en           = 1'b0;
    mem_rd_en           = 1'b0;
    mem_rd_addr         = tos_s;
    slide_req.start     = 1'b0;
    slide_req.start_seq = base_r;
    slide_req.limit_seq = next_r;

    case (state_r)
      S_IDLE: begin
        // Capture the item; keep only the stored payload width
        if (in_valid) begin
          func_nxt  = in_func;
          pay_nxt   = in_payload_word[PAYLOAD_WIDTH-1:0];
          ack_nxt   = in_ack_number;
          ok_nxt    = in_checksum_ok;
          tos_nxt   = in_timed_out_seq;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_EMIT;
        case (func_r)
          FUNC_SEND: begin
            // Refuse while the window is full
            if (next_r != seq_add_win(base_r)) begin
              mem_wr_en            = 1'b1;
              acked_nxt[next_r]    = 1'b0;
              res_nxt.accepted     = 1'b1;
              res_nxt.transmit     = 1'b1;
              res_nxt.tx_seq       = next_r;
              res_nxt.tx_payload   = pay_r;
              res_nxt.timer_action = TMR_RESTART;
              res_nxt.timer_slot   = next_r;
              next_nxt             = seq_inc(next_r);
            end
          end
          FUNC_ACK: begin
            // Drop acks with bad checksum, outside the window, or with
            // nothing outstanding
            if (base_r != next_r && ok_r && int'(ack_r) < SEQ_SPACE &&
                int'(seq_dist(ack_s, base_r)) < WINDOW_SIZE) begin
              acked_nxt[ack_s]     = 1'b1;
              res_nxt.timer_action = TMR_STOP;
              res_nxt.timer_slot   = ack_s;
              if (ack_s == base_r) begin
                slide_req.start = 1'b1;
                state_nxt       = S_SLIDE;
              end
            end
          end
          FUNC_TIMEOUT: begin
            if (int'(tos_r) < SEQ_SPACE) begin
              mem_rd_en            = 1'b1;
              res_nxt.transmit     = 1'b1;
              res_nxt.tx_seq       = tos_s;
              res_nxt.timer_action = TMR_RESTART;
              res_nxt.timer_slot   = tos_s;
              state_nxt            = S_READ;
            end
          end
          default: begin
            // Unused code: report the window only
          end
        endcase
      end

      S_SLIDE: begin
        // Wait for the slide unit to find the new base
        if (slide_sts.done) begin
          base_nxt  = slide_sts.base;
          state_nxt = S_EMIT;
        end
      end

      S_READ: begin
        res_nxt.tx_payload = mem_rd_data;
        state_nxt          = S_EMIT;
      end

      S_EMIT: begin
        // Load the output register once it is free or being taken
        if (!out_valid_r || out_ready) begin
          out_res_nxt   = res_r;
          out_base_nxt  = base_r;
          out_next_nxt  = next_r;
          out_full_nxt  = (next_r == seq_add_win(base_r));
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      acked_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      acked_r     <= acked_nxt;
      out_valid_r <= out_valid_nxt;
      func_r      <= func_nxt;
      pay_r       <= pay_nxt;
      ack_r       <= ack_nxt;
      ok_r        <= ok_nxt;
      tos_r       <= tos_nxt;
      res_r       <= res_nxt;
      out_res_r   <= out_res_nxt;
      out_base_r  <= out_base_nxt;
      out_next_r  <= out_next_nxt;
      out_full_r  <= out_full_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_res_r.accepted;
  assign out_transmit      = out_res_r.transmit;
  assign out_tx_seq        = SEQ_FW'(out_res_r.tx_seq);
  assign out_tx_payload    = PAY_FW'(out_res_r.tx_payload);
  assign out_timer_action  = out_res_r.timer_action;
  assign out_timer_slot    = SEQ_FW'(out_res_r.timer_slot);
  assign out_window_base   = SEQ_FW'(out_base_r);
  assign out_next_sequence = SEQ_FW'(out_next_r);
  assign out_window_full   = out_full_r;

  // One item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is still at work");

  // Outstanding count never exceeds the window
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(seq_dist(next_r, base_r)) <= WINDOW_SIZE)
    else $error("window holds more than its size");

  // Every transmission restarts the timer of the sent slot
  a_tx_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_transmit) |->
      (out_timer_action == TMR_RESTART && out_timer_slot == out_tx_seq))
    else $error("transmit without a matching timer restart");

  // A taken send always transmits
  a_accept_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> out_transmit)
    else $error("send taken without transmission");

endmodule

FILE: tb/selective_repeat_sender_window_test.sv
`timescale 1ns / 1ps

module selective_repeat_sender_window_test;
  import srsw_pkg::*;

  // Cycles with no handshake on either channel before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  // One result item as the block should report it
  typedef struct packed {
    logic        accepted;
    logic        transmit;
    seq_t        tx_seq;
    logic [63:0] tx_payload;
    timer_t      timer_action;
    seq_t        timer_slot;
    seq_t        window_base;
    seq_t        next_sequence;
    logic        window_full;
  } tx_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_SEND;
  logic [63:0] in_payload_word = '0;
  logic [2:0]  in_ack_number = '0;
  logic        in_checksum_ok = 1'b0;
  logic [2:0]  in_timed_out_seq = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic        out_transmit;
  logic [2:0]  out_tx_seq;
  logic [63:0] out_tx_payload;
  logic [1:0]  out_timer_action;
  logic [2:0]  out_timer_slot;
  logic [2:0]  out_window_base;
  logic [2:0]  out_next_sequence;
  logic        out_window_full;

  // Shadow copy of the sender window, advanced at every accepted input item
  seq_t        win_base = '0;
  seq_t        win_next = '0;
  logic        slot_acked   [SEQ_SPACE];
  logic [63:0] slot_payload [SEQ_SPACE];
  // Slots that have held a sent payload; only these may be timed out
  logic        slot_written [SEQ_SPACE];

  tx_report_t  tx_report_q[$];

  int          mismatches   = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          rx_hold_len  = 0;
  bit          tx_idle_en   = 1'b1;
  bit          rx_idle_en   = 1'b1;

  selective_repeat_sender_window u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_payload_word   (in_payload_word),
    .in_ack_number     (in_ack_number),
    .in_checksum_ok    (in_checksum_ok),
    .in_timed_out_seq  (in_timed_out_seq),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_transmit      (out_transmit),
    .out_tx_seq        (out_tx_seq),
    .out_tx_payload    (out_tx_payload),
    .out_timer_action  (out_timer_action),
    .out_timer_slot    (out_timer_slot),
    .out_window_base   (out_window_base),
    .out_next_sequence (out_next_sequence),
    .out_window_full   (out_window_full)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int s = 0; s < SEQ_SPACE; s++) begin
      slot_acked[s]   = 1'b0;
      slot_payload[s] = '0;
      slot_written[s] = 1'b0;
    end
  end

  // Random sequence number and bit for fields an event does not use
  function automatic seq_t rnd_seq();
    return seq_t'($urandom_range(0, SEQ_SPACE - 1));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Window predictor
  // ---------------------------------------------------------------------------

  // The window is full once next sits a whole window ahead of base. The
  // sequence space is a power of two, so 3-bit wrap is the modulo.
  function automatic logic window_is_full();
    return win_next == seq_t'(win_base + WINDOW_SIZE);
  endfunction

  // Apply one event to the shadow window and return the result it must cause.
  function automatic tx_report_t window_predict(input func_t fn, input logic [63:0] word,
                                                input seq_t ack, input logic ok,
                                                input seq_t tmo);
    tx_report_t r;
    seq_t       walk;
    r = '0;
    case (fn)
      FUNC_SEND: begin
        // Refuse while full; otherwise store, clear the flag, transmit, arm timer
        if (!window_is_full()) begin
          slot_payload[win_next] = word;
          slot_acked[win_next]   = 1'b0;
          slot_written[win_next] = 1'b1;
          r.accepted     = 1'b1;
          r.transmit     = 1'b1;
          r.tx_seq       = win_next;
          r.tx_payload   = word;
          r.timer_action = TMR_RESTART;
          r.timer_slot   = win_next;
          win_next       = win_next + seq_t'(1);
        end
      end
      FUNC_ACK: begin
        // Drop acks with nothing outstanding, a bad checksum, or outside the window.
        // An ack of a slot not yet sent is still marked.
        if (win_base != win_next && ok && int'(seq_t'(ack - win_base)) < WINDOW_SIZE) begin
          slot_acked[ack] = 1'b1;
          r.timer_action  = TMR_STOP;
          r.timer_slot    = ack;
          if (ack == win_base) begin
            // Slide past acked slots, never beyond next
            walk = win_base;
            while (walk != win_next && slot_acked[walk]) walk = walk + seq_t'(1);
            win_base = walk;
          end
        end
      end
      FUNC_TIMEOUT: begin
        // Resend the stored packet and restart its timer
        r.transmit     = 1'b1;
        r.tx_seq       = tmo;
        r.tx_payload   = slot_payload[tmo];
        r.timer_action = TMR_RESTART;
        r.timer_slot   = tmo;
      end
      default: ;
    endcase
    r.window_base   = win_base;
    r.next_sequence = win_next;
    r.window_full   = window_is_full();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one event and hold it until taken. Valid stays high between
  // back-to-back items; this task drops it only when an idle gap is chosen.
  task automatic offer_event(input func_t fn, input logic [63:0] word, input seq_t ack,
                             input logic ok, input seq_t tmo);
    if (tx_idle_en && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 33);
    end
    in_valid         <= 1'b1;
    in_func          <= fn;
    in_payload_word  <= word;
    in_ack_number    <= ack;
    in_checksum_ok   <= ok;
    in_timed_out_seq <= tmo;
    do @(posedge clk); while (!in_ready);
    tx_report_q.push_back(window_predict(fn, word, ack, ok, tmo));
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Drive ready: a requested hold-off wins, then random idling, else always ready
  always @(posedge clk) begin
    if (rx_hold_len > 0) begin
      out_ready   <= 1'b0;
      rx_hold_len <= rx_hold_len - 1;
    end else if (rx_idle_en) begin
      out_ready <= ($urandom_range(0, 99) >= 33);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [63:0] got,
                                      input logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h got %h", results_seen, name, want, got);
    end
  endfunction

  // Compare every accepted result item against the oldest prediction
  always @(posedge clk) begin : check_results
    tx_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tx_report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: item arrived with nothing expected", results_seen);
      end else begin
        want = tx_report_q.pop_front();
        check_field("accepted",      64'(out_accepted),      64'(want.accepted));
        check_field("transmit",      64'(out_transmit),      64'(want.transmit));
        check_field("tx_seq",        64'(out_tx_seq),        64'(want.tx_seq));
        check_field("tx_payload",    out_tx_payload,         want.tx_payload);
        check_field("timer_action",  64'(out_timer_action),  64'(want.timer_action));
        check_field("timer_slot",    64'(out_timer_slot),    64'(want.timer_slot));
        check_field("window_base",   64'(out_window_base),   64'(want.window_base));
        check_field("next_sequence", 64'(out_next_sequence), 64'(want.next_sequence));
        check_field("window_full",   64'(out_window_full),   64'(want.window_full));
      end
      results_seen++;
    end
  end

  // Hang detection: count cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Acks right after reset: nothing is outstanding, so both must be dropped
  task automatic test_idle_acks();
    offer_event(FUNC_ACK, {$urandom, $urandom}, 3'd0, 1'b1, rnd_seq());
    offer_event(FUNC_ACK, {$urandom, $urandom}, 3'd5, 1'b0, rnd_seq());
  endtask

  // Walk the window through fill, refusal, drops, resends, slides and wrap
  task automatic test_directed_window();
    // Fill the window with extreme payloads, then hit it while full
    offer_event(FUNC_SEND, '1,               rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_SEND, '0,               rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_SEND, {32{2'b10}},      rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_SEND, {32{2'b01}},      rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_SEND, {$urandom, $urandom}, rnd_seq(), rnd_bit(), rnd_seq());
    // Bad checksum, then an ack outside the window
    offer_event(FUNC_ACK, '0, 3'd1, 1'b0, rnd_seq());
    offer_event(FUNC_ACK, '0, 3'd5, 1'b1, rnd_seq());
    // Out-of-order ack, resends, then a base ack that slides over marked slots
    offer_event(FUNC_ACK,     '0, 3'd2, 1'b1, rnd_seq());
    offer_event(FUNC_TIMEOUT, '0, rnd_seq(), rnd_bit(), 3'd3);
    offer_event(FUNC_TIMEOUT, '0, rnd_seq(), rnd_bit(), 3'd0);
    offer_event(FUNC_ACK,     '0, 3'd1, 1'b1, rnd_seq());
    offer_event(FUNC_ACK,     '0, 3'd0, 1'b1, rnd_seq());
    offer_event(FUNC_ACK,     '0, 3'd3, 1'b1, rnd_seq());
    // Ack a slot not yet sent: the slide stops at next, a later send clears it
    offer_event(FUNC_SEND, {$urandom, $urandom}, rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_ACK,  '0, 3'd6, 1'b1, rnd_seq());
    offer_event(FUNC_ACK,  '0, 3'd4, 1'b1, rnd_seq());
    offer_event(FUNC_SEND, {$urandom, $urandom}, rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_SEND, {$urandom, $urandom}, rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_ACK,  '0, 3'd5, 1'b1, rnd_seq());
    // Wrap the sequence numbers and slide across the wrap
    offer_event(FUNC_SEND, {$urandom, $urandom}, rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_SEND, {$urandom, $urandom}, rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_SEND, {$urandom, $urandom}, rnd_seq(), rnd_bit(), rnd_seq());
    offer_event(FUNC_ACK,  '0, 3'd7, 1'b0, rnd_seq());
    offer_event(FUNC_ACK,  '0, 3'd7, 1'b1, rnd_seq());
    offer_event(FUNC_ACK,  '0, 3'd0, 1'b1, rnd_seq());
    offer_event(FUNC_ACK,  '0, 3'd6, 1'b1, rnd_seq());
    offer_event(FUNC_TIMEOUT, '0, rnd_seq(), rnd_bit(), 3'd7);
    offer_event(FUNC_ACK,  '0, 3'd6, 1'b1, rnd_seq());
  endtask

  // Mostly protocol-shaped traffic: acks of outstanding slots (often the base,
  // so the window keeps sliding) and timeouts of sent slots, plus noise acks.
  task automatic test_random_traffic(input int count);
    int          pick;
    int          outstanding;
    int          slot;
    logic [63:0] word;
    seq_t        sent_slots[$];
    repeat (count) begin
      outstanding = int'(seq_t'(win_next - win_base));
      pick = $urandom_range(0, 99);
      word = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) word = $urandom_range(0, 1) ? '1 : '0;
      sent_slots = {};
      for (int s = 0; s < SEQ_SPACE; s++) if (slot_written[s]) sent_slots.push_back(seq_t'(s));
      // Never time out a slot that was never written
      if (pick >= 85 && sent_slots.size() == 0) pick = 0;
      if (pick < 45) begin
        offer_event(FUNC_SEND, word, rnd_seq(), rnd_bit(), rnd_seq());
      end else if (pick < 85) begin
        if (outstanding > 0 && $urandom_range(0, 99) < 85) begin
          slot = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(0, outstanding - 1);
          offer_event(FUNC_ACK, word, seq_t'(win_base + slot), 1'b1, rnd_seq());
        end else begin
          offer_event(FUNC_ACK, word, rnd_seq(), rnd_bit(), rnd_seq());
        end
      end else begin
        if (outstanding > 0 && $urandom_range(0, 99) < 75)
          slot = int'(seq_t'(win_base + $urandom_range(0, outstanding - 1)));
        else
          slot = sent_slots[$urandom_range(0, sent_slots.size() - 1)];
        offer_event(FUNC_TIMEOUT, word, rnd_seq(), rnd_bit(), seq_t'(slot));
      end
    end
  endtask

  // Hold the receiver off while items keep coming, so the block backs up
  // and drops in_ready
  task automatic test_receiver_hold_off();
    rx_hold_len <= HOLD_CYCLES;
    test_random_traffic(16);
  endtask

  // Stop offering until every result is back, then resume
  task automatic test_sender_pause();
    in_valid <= 1'b0;
    wait (tx_report_q.size() == 0);
    @(posedge clk);
    test_random_traffic(20);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_acks();
    test_directed_window();
    test_random_traffic(400);

    // Long stretch with both sides always ready
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(200);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    test_receiver_hold_off();
    test_sender_pause();
    test_random_traffic(330);

    // Drain: wait for the last results, then a few quiet cycles for strays
    in_valid <= 1'b0;
    wait (tx_report_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && tx_report_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
